// ===== design/sng_pkg.sv =====
`default_nettype none

package sng_pkg;

  localparam int unsigned MT_N      = 624;
  localparam int unsigned MT_M      = 397;
  localparam int unsigned MT_ADDR_W = 10;
  localparam int unsigned SAMPLE_W  = 18;
  localparam int unsigned PHASE_W   = 24;
  localparam int unsigned ROM_N     = 257;

  localparam logic [31:0] RESET_SEED  = 32'd5489;
  localparam logic [31:0] SEED_MULT   = 32'd1812433253;
  localparam logic [31:0] MT_MATRIX   = 32'h9908b0df;
  localparam logic [29:0] RAD_TO_TURN = 30'd683565276;

  localparam logic signed [18:0] Q_ONE     = 19'sd65536;
  localparam logic signed [18:0] C_WHITE   = 19'sd58982;
  localparam logic signed [18:0] C_BROWN_K = 19'sd9830;
  localparam logic signed [18:0] C_RAIN_K  = 19'sd26214;
  localparam logic signed [18:0] C_TEST_K  = 19'sd13107;
  localparam logic signed [18:0] C_TENTH   = 19'sd6554;

  typedef logic [MT_ADDR_W-1:0] mt_addr_t;

  typedef enum logic [1:0] {
    MODE_WHITE = 2'd0,
    MODE_BROWN = 2'd1,
    MODE_RAIN  = 2'd2,
    MODE_TEST  = 2'd3
  } mode_t;

  typedef enum logic {
    REG_MODE = 1'b0,
    REG_SEED = 1'b1
  } reg_index_t;

  typedef enum logic [4:0] {
    OP_NONE   = 5'd0,
    OP_SEED0  = 5'd1,
    OP_SEED   = 5'd2,
    OP_ACCEPT = 5'd3,
    OP_RD0    = 5'd4,
    OP_RD1    = 5'd5,
    OP_RD2    = 5'd6,
    OP_RD3    = 5'd7,
    OP_GEN    = 5'd8,
    OP_MUL_A  = 5'd9,
    OP_RND    = 5'd10,
    OP_MUL_B  = 5'd11,
    OP_MUL_C  = 5'd12,
    OP_UPD    = 5'd13,
    OP_MUL_D  = 5'd14,
    OP_INC    = 5'd15,
    OP_PH     = 5'd16,
    OP_ROM    = 5'd17,
    OP_RES    = 5'd18,
    OP_OUT    = 5'd19
  } op_t;

  typedef struct packed {
    op_t  op;
    logic chan;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  seed_last;
    logic  out_free;
  } status_t;

  typedef logic [ROM_N-1:0][16:0] sine_rom_t;

  function automatic logic [63:0] series_div(input logic [63:0] v, input int n);
    logic [63:0] q;
    unique case (n)
      1:       q = v / 64'd6;
      2:       q = v / 64'd20;
      3:       q = v / 64'd42;
      4:       q = v / 64'd72;
      5:       q = v / 64'd110;
      6:       q = v / 64'd156;
      7:       q = v / 64'd210;
      8:       q = v / 64'd272;
      default: q = v / 64'd342;
    endcase
    return q;
  endfunction

  function automatic logic [16:0] sine_base(input logic [8:0] m);
    logic [63:0] r;
    logic [63:0] th;
    logic [63:0] term;
    logic [63:0] sum;
    r    = 64'(m) << 22;
    th   = (r * 64'd1686629713) >> 30;
    term = th;
    sum  = th;
    for (int n = 1; n <= 9; n++) begin
      term = series_div((((term * th) >> 30) * th) >> 30, n);
      if ((n & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return 17'((sum + 64'd8192) >> 14);
  endfunction

  function automatic sine_rom_t sine_rom_build();
    sine_rom_t rom;
    for (int m = 0; m < ROM_N; m++) begin
      rom[m] = sine_base(9'(m));
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// ===== design/sng_ctrl.sv =====
`default_nettype none

module sng_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              frame_tick,
  input  logic              seed_wr,
  input  sng_pkg::status_t  status,
  output sng_pkg::cmd_t     cmd,
  output logic              s_tready
);

  typedef enum logic [21:0] {
    ST_SEED0 = 22'h000001,
    ST_SEED  = 22'h000002,
    ST_IDLE  = 22'h000004,
    ST_RD0   = 22'h000008,
    ST_RD1   = 22'h000010,
    ST_RD2   = 22'h000020,
    ST_RD3   = 22'h000040,
    ST_GEN   = 22'h000080,
    ST_MUL_A = 22'h000100,
    ST_RND_A = 22'h000200,
    ST_MUL_B = 22'h000400,
    ST_RND_B = 22'h000800,
    ST_MUL_C = 22'h001000,
    ST_RND_C = 22'h002000,
    ST_UPD   = 22'h004000,
    ST_MUL_D = 22'h008000,
    ST_RND_D = 22'h010000,
    ST_INC   = 22'h020000,
    ST_PH    = 22'h040000,
    ST_ROM   = 22'h080000,
    ST_RES   = 22'h100000,
    ST_OUT   = 22'h200000
  } state_t;

  state_t state;
  state_t state_next;
  logic   chan;
  logic   chan_next;

  assign s_tready = (state == ST_IDLE) && !seed_wr;

  always_comb begin
    state_next = state;
    chan_next  = chan;
    cmd.op     = sng_pkg::OP_NONE;
    cmd.chan   = chan;
    unique case (state)
      ST_SEED0: begin
        cmd.op     = sng_pkg::OP_SEED0;
        state_next = ST_SEED;
      end
      ST_SEED: begin
        cmd.op = sng_pkg::OP_SEED;
        if (status.seed_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid && s_tready && frame_tick) begin
          cmd.op     = sng_pkg::OP_ACCEPT;
          chan_next  = 1'b0;
          state_next = ST_RD0;
        end
      end
      ST_RD0: begin
        cmd.op     = sng_pkg::OP_RD0;
        state_next = ST_RD1;
      end
      ST_RD1: begin
        cmd.op     = sng_pkg::OP_RD1;
        state_next = ST_RD2;
      end
      ST_RD2: begin
        cmd.op     = sng_pkg::OP_RD2;
        state_next = ST_RD3;
      end
      ST_RD3: begin
        cmd.op     = sng_pkg::OP_RD3;
        state_next = ST_GEN;
      end
      ST_GEN: begin
        cmd.op     = sng_pkg::OP_GEN;
        state_next = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd.op     = sng_pkg::OP_MUL_A;
        state_next = ST_RND_A;
      end
      ST_RND_A: begin
        cmd.op     = sng_pkg::OP_RND;
        state_next = (status.mode == sng_pkg::MODE_WHITE) ? ST_RES : ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.op     = sng_pkg::OP_MUL_B;
        state_next = ST_RND_B;
      end
      ST_RND_B: begin
        cmd.op     = sng_pkg::OP_RND;
        state_next = ST_MUL_C;
      end
      ST_MUL_C: begin
        cmd.op     = sng_pkg::OP_MUL_C;
        state_next = ST_RND_C;
      end
      ST_RND_C: begin
        cmd.op     = sng_pkg::OP_RND;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.op     = sng_pkg::OP_UPD;
        state_next = (status.mode == sng_pkg::MODE_TEST) ? ST_MUL_D : ST_RES;
      end
      ST_MUL_D: begin
        cmd.op     = sng_pkg::OP_MUL_D;
        state_next = ST_RND_D;
      end
      ST_RND_D: begin
        cmd.op     = sng_pkg::OP_RND;
        state_next = ST_INC;
      end
      ST_INC: begin
        cmd.op     = sng_pkg::OP_INC;
        state_next = ST_PH;
      end
      ST_PH: begin
        cmd.op     = sng_pkg::OP_PH;
        state_next = ST_ROM;
      end
      ST_ROM: begin
        cmd.op     = sng_pkg::OP_ROM;
        state_next = ST_RES;
      end
      ST_RES: begin
        cmd.op = sng_pkg::OP_RES;
        if (!chan) begin
          chan_next  = 1'b1;
          state_next = ST_RD0;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd.op = sng_pkg::OP_OUT;
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_SEED0;
      end
    endcase
    // restart the seeding pass on every seed write
    if (seed_wr) begin
      state_next = ST_SEED0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SEED0;
      chan  <= 1'b0;
    end else begin
      state <= state_next;
      chan  <= chan_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/sng_datapath.sv =====
`default_nettype none

module sng_datapath (
  input  logic              clk,
  input  logic              rst,
  input  sng_pkg::cmd_t     cmd,
  output sng_pkg::status_t  status,
  input  logic              mode_wr,
  input  logic              seed_wr,
  input  logic [31:0]       cfg_data,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [39:0]       m_tdata
);

  localparam sng_pkg::sine_rom_t SINE_ROM = sng_pkg::sine_rom_build();

  sng_pkg::mode_t      mode;
  logic [31:0]         seed;
  logic [31:0]         mt_mem [sng_pkg::MT_N];
  logic [31:0]         rdata;
  logic [31:0]         wa;
  logic [31:0]         wb;
  logic [31:0]         wc;
  sng_pkg::mt_addr_t   ptr;
  sng_pkg::mt_addr_t   seed_cnt;
  logic [31:0]         seed_prev;
  logic signed [17:0]  u;
  logic signed [17:0]  fl [2];
  logic signed [17:0]  x [2];
  logic [23:0]         phase [2];
  logic signed [37:0]  prod;
  logic signed [19:0]  qv;
  logic [43:0]         incp;
  logic [16:0]         rom_val;
  logic                rom_neg;
  logic signed [17:0]  res [2];

  sng_pkg::mt_addr_t   ptr_inc;
  sng_pkg::mt_addr_t   ptr_far;
  sng_pkg::mt_addr_t   mem_raddr;
  sng_pkg::mt_addr_t   mem_waddr;
  logic                mem_we;
  logic [31:0]         mem_wdata;
  logic [31:0]         seed_mix;
  logic [31:0]         seed_word;
  logic [31:0]         tw_y;
  logic [31:0]         tw_word;
  logic [31:0]         t1;
  logic [31:0]         t2;
  logic [31:0]         t3;
  logic [31:0]         t4;
  logic signed [18:0]  xe;
  logic signed [18:0]  ma;
  logic signed [18:0]  mb;
  logic signed [37:0]  rnd_sum;
  logic signed [19:0]  xn;
  logic [43:0]         inc_sum;
  logic [9:0]          sidx;
  logic [8:0]          rom_addr;
  logic signed [17:0]  sine_val;

  assign status.mode      = mode;
  assign status.seed_last = (seed_cnt == sng_pkg::mt_addr_t'(sng_pkg::MT_N - 1));
  assign status.out_free  = !m_tvalid || m_tready;

  assign ptr_inc = (ptr == sng_pkg::mt_addr_t'(sng_pkg::MT_N - 1)) ? '0 : ptr + 1'b1;
  assign ptr_far = (ptr < sng_pkg::mt_addr_t'(sng_pkg::MT_N - sng_pkg::MT_M))
                 ? ptr + sng_pkg::mt_addr_t'(sng_pkg::MT_M)
                 : ptr - sng_pkg::mt_addr_t'(sng_pkg::MT_N - sng_pkg::MT_M);

  assign seed_mix  = seed_prev ^ (seed_prev >> 30);
  assign seed_word = 32'(sng_pkg::SEED_MULT * seed_mix) + 32'(seed_cnt);

  assign tw_y    = {wa[31], wb[30:0]};
  assign tw_word = wc ^ (tw_y >> 1) ^ (tw_y[0] ? sng_pkg::MT_MATRIX : 32'd0);
  assign t1      = tw_word ^ (tw_word >> 11);
  assign t2      = t1 ^ ((t1 << 7) & 32'h9d2c5680);
  assign t3      = t2 ^ ((t2 << 15) & 32'hefc60000);
  assign t4      = t3 ^ (t3 >> 18);

  assign xe      = {x[cmd.chan][17], x[cmd.chan]};
  assign rnd_sum = prod + 38'sd32768;
  assign xn      = {{2{x[cmd.chan][17]}}, x[cmd.chan]} + qv;
  assign inc_sum = incp + 44'd8388608;

  assign sidx     = phase[cmd.chan][23:14];
  assign rom_addr = sidx[8] ? 9'd256 - {1'b0, sidx[7:0]} : {1'b0, sidx[7:0]};
  assign sine_val = rom_neg ? -$signed({1'b0, rom_val}) : $signed({1'b0, rom_val});

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = tw_word;
    mem_raddr = ptr;
    unique case (cmd.op)
      sng_pkg::OP_SEED0: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = seed;
      end
      sng_pkg::OP_SEED: begin
        mem_we    = 1'b1;
        mem_waddr = seed_cnt;
        mem_wdata = seed_word;
      end
      sng_pkg::OP_GEN: begin
        mem_we = 1'b1;
      end
      sng_pkg::OP_RD1: begin
        mem_raddr = ptr_inc;
      end
      sng_pkg::OP_RD2: begin
        mem_raddr = ptr_far;
      end
      default: begin
        mem_raddr = ptr;
      end
    endcase
  end

  always_comb begin
    ma = {u[17], u};
    mb = sng_pkg::Q_ONE;
    unique case (cmd.op)
      sng_pkg::OP_MUL_A: begin
        ma = {u[17], u};
        unique case (mode)
          sng_pkg::MODE_WHITE: mb = sng_pkg::C_WHITE;
          sng_pkg::MODE_BROWN: mb = sng_pkg::Q_ONE;
          default:             mb = {fl[~cmd.chan][17], fl[~cmd.chan]};
        endcase
      end
      sng_pkg::OP_MUL_B: begin
        ma = qv[18:0];
        mb = sng_pkg::Q_ONE + (qv[19] ? xe : -xe);
      end
      sng_pkg::OP_MUL_C: begin
        ma = qv[18:0];
        unique case (mode)
          sng_pkg::MODE_BROWN: mb = sng_pkg::C_BROWN_K;
          sng_pkg::MODE_RAIN:  mb = sng_pkg::C_RAIN_K;
          default:             mb = sng_pkg::C_TEST_K;
        endcase
      end
      sng_pkg::OP_MUL_D: begin
        ma = xe + sng_pkg::Q_ONE;
        mb = sng_pkg::C_TENTH;
      end
      default: begin
        ma = {u[17], u};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mt_mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mt_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= sng_pkg::MODE_WHITE;
      seed     <= sng_pkg::RESET_SEED;
      ptr      <= '0;
      seed_cnt <= '0;
      x[0]     <= '0;
      x[1]     <= '0;
      phase[0] <= '0;
      phase[1] <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (mode_wr) begin
        mode <= sng_pkg::mode_t'(cfg_data[1:0]);
      end
      if (seed_wr) begin
        seed <= cfg_data;
      end
      if (cmd.op == sng_pkg::OP_OUT && status.out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (cmd.op)
        sng_pkg::OP_SEED0: begin
          seed_prev <= seed;
          seed_cnt  <= sng_pkg::mt_addr_t'(1);
          ptr       <= '0;
        end
        sng_pkg::OP_SEED: begin
          seed_prev <= seed_word;
          seed_cnt  <= seed_cnt + 1'b1;
        end
        sng_pkg::OP_ACCEPT: begin
          for (int c = 0; c < 2; c++) begin
            fl[c] <= (x[c] > -18'sd6554 && x[c] < 18'sd6554) ? 18'sd6554 : x[c];
          end
        end
        sng_pkg::OP_RD1: wa <= rdata;
        sng_pkg::OP_RD2: wb <= rdata;
        sng_pkg::OP_RD3: wc <= rdata;
        sng_pkg::OP_GEN: begin
          u   <= $signed({1'b0, t4[31:15]}) - 18'sd65536;
          ptr <= ptr_inc;
        end
        sng_pkg::OP_MUL_A, sng_pkg::OP_MUL_B, sng_pkg::OP_MUL_C, sng_pkg::OP_MUL_D: begin
          prod <= 38'(ma) * 38'(mb);
        end
        sng_pkg::OP_RND: begin
          qv <= rnd_sum[35:16];
        end
        sng_pkg::OP_UPD: begin
          if (xn > 20'sd65536 || xn < -20'sd65536) begin
            x[cmd.chan] <= '0;
          end else begin
            x[cmd.chan] <= xn[17:0];
          end
        end
        sng_pkg::OP_INC: begin
          incp <= 44'(qv[13:0]) * 44'(sng_pkg::RAD_TO_TURN);
        end
        sng_pkg::OP_PH: begin
          phase[cmd.chan] <= phase[cmd.chan] + 24'(inc_sum[43:24]);
        end
        sng_pkg::OP_ROM: begin
          rom_val <= SINE_ROM[rom_addr];
          rom_neg <= sidx[9];
        end
        sng_pkg::OP_RES: begin
          unique case (mode)
            sng_pkg::MODE_WHITE: res[cmd.chan] <= qv[17:0];
            sng_pkg::MODE_TEST:  res[cmd.chan] <= sine_val;
            default:             res[cmd.chan] <= x[cmd.chan];
          endcase
        end
        sng_pkg::OP_OUT: begin
          if (status.out_free) begin
            m_tdata <= {4'b0000, res[1], res[0]};
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    x[0] <= 18'sd65536 && x[0] >= -18'sd65536 &&
    x[1] <= 18'sd65536 && x[1] >= -18'sd65536)
    else $error("walk level out of range");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr < sng_pkg::mt_addr_t'(sng_pkg::MT_N))
    else $error("twister pointer out of range");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.op == sng_pkg::OP_OUT && status.out_free |=> m_tvalid)
    else $error("frame not loaded into output register");
`endif

endmodule

`default_nettype wire

// ===== design/stereo_noise_generator_core.sv =====
// Frames: white skips the walk steps, brown and rain run them, the sine test adds phase and ROM
// steps. No new frame is taken until the last is in the output register; the pace is set by the
// twister memory (four accesses per draw, two draws per frame) and one multiplier shared by the
// walk steps. Reset (rst, synchronous): seeds the 624-word twister memory in one pass with
// s_tready low; a seed write starts the same pass again. Walk levels and phases clear on reset.
`default_nettype none

module stereo_noise_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [0] frame_tick
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,    // [17:0] left_sample, [35:18] right_sample
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  sng_pkg::cmd_t    cmd;
  sng_pkg::status_t status;
  logic             mode_wr;
  logic             seed_wr;

  assign cfg_ready = 1'b1;
  assign mode_wr   = cfg_valid && (cfg_index == sng_pkg::REG_MODE);
  assign seed_wr   = cfg_valid && (cfg_index == sng_pkg::REG_SEED);

  sng_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .frame_tick (s_tdata[0]),
    .seed_wr    (seed_wr),
    .status     (status),
    .cmd        (cmd),
    .s_tready   (s_tready)
  );

  sng_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .mode_wr  (mode_wr),
    .seed_wr  (seed_wr),
    .cfg_data (cfg_data),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
